### sv/espar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espar_pkg
// Types, constants and helpers for the effect slot pool.
// ----------------------------------------------------------------------------
package espar_pkg;

    localparam int SLOTS_DEF        = 16;
    localparam int TIME_BITS_DEF    = 20;
    localparam int MIN_LIFETIME_DEF = 205;

    localparam int IN_TIME_W = 20;
    localparam int IDX_W     = 4;
    localparam int SEED_W    = 32;
    localparam int CNT_W     = 5;

    localparam logic [SEED_W-1:0] RNG_RESET = 32'h9e37_79b9;

    localparam logic FUNC_SPAWN = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_WRITE,
        ST_TICK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic tick;
        logic write;
    } t_head_cmd;

    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] w);
        logic [SEED_W-1:0] x;
        x = (w == '0) ? RNG_RESET : w;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage
`default_nettype wire

### sv/espar_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espar_in_if / espar_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface espar_in_if import espar_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [IN_TIME_W-1:0] lifetime_req;
    logic [IN_TIME_W-1:0] elapsed;

    modport source (output valid, output func, output lifetime_req, output elapsed,
                    input ready);
    modport sink   (input valid, input func, input lifetime_req, input elapsed,
                    output ready);
endinterface

interface espar_out_if import espar_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  slot_index;
    logic              replaced_live;
    logic [SEED_W-1:0] seed_word;
    logic [CNT_W-1:0]  expired_count;
    logic [CNT_W-1:0]  live_count;

    modport source (output valid, output slot_index, output replaced_live,
                    output seed_word, output expired_count, output live_count,
                    input ready);
    modport sink   (input valid, input slot_index, input replaced_live,
                    input seed_word, input expired_count, input live_count,
                    output ready);
endinterface
`default_nettype wire

### sv/effect_slot_pool_age_replace_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// effect_slot_pool_age_replace_unit
// Slot pool with lowest-free allocation and furthest-through-life replacement.
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that rotates one slot per cycle, while
// shifting (scan compare, write, tick), past a single update unit. A tick
// ages and retires each slot, then posts the result. A spawn scans each
// slot with a cross-multiply, then a compare, to find the lowest free slot
// or the slot furthest through its life, then makes one full rotation to
// write the chosen slot, then posts the result. One request item is
// worked at a time; a new one is taken while the previous result waits.
// ----------------------------------------------------------------------------
module effect_slot_pool_age_replace_unit import espar_pkg::*; #(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF,
    parameter int MIN_LIFETIME = MIN_LIFETIME_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    espar_in_if.sink     i_in,
    espar_out_if.source  o_out
);

    localparam int TW  = TIME_BITS;
    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam longint unsigned TMAX = (64'd1 << TW) - 64'd1;
    localparam logic [TW-1:0] MIN_EFF =
        (longint'(MIN_LIFETIME) > TMAX) ? {TW{1'b1}} : TW'(MIN_LIFETIME);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state r_state, n_state;

    logic          r_found;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_best_idx;
    logic [TW-1:0] r_best_age;
    logic [TW-1:0] r_best_life;
    logic [2*TW-1:0] r_prod_l;
    logic [2*TW-1:0] r_prod_r;
    logic [IW-1:0] r_idx;
    logic          r_func;
    logic [TW-1:0] r_life_new;
    logic [TW-1:0] r_dt;
    logic [CW-1:0] r_live_cnt;
    logic [CW-1:0] r_exp_cnt;
    logic [SEED_W-1:0] r_rng;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_repl;
    logic [SEED_W-1:0] r_out_seed;
    logic [CNT_W-1:0]  r_out_exp;
    logic [CNT_W-1:0]  r_out_live;

    logic          c_live [SLOTS];
    logic [TW-1:0] c_age  [SLOTS];
    logic [TW-1:0] c_life [SLOTS];

    logic          h_live;
    logic [TW-1:0] h_age;
    logic [TW-1:0] h_life;
    logic          h_expired;
    t_head_cmd     head_cmd;
    logic          shift;
    logic [IW-1:0] pick;
    logic          in_acc;
    logic          out_load;
    logic [TW-1:0] req_t;
    logic [SEED_W-1:0] rng_next;

    assign in_acc   = i_in.valid && i_in.ready;
    assign pick     = r_found ? r_free_idx : r_best_idx;
    assign req_t    = TW'(i_in.lifetime_req);
    assign rng_next = xorshift32(r_rng);
    assign shift    = (r_state == ST_SCAN_CMP) || (r_state == ST_WRITE)
                   || (r_state == ST_TICK);
    assign head_cmd.tick  = (r_state == ST_TICK);
    assign head_cmd.write = (r_state == ST_WRITE) && (r_idx == pick);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    espar_head #(.TW(TW)) u_head (
        .i_cmd      (head_cmd),
        .i_dt       (r_dt),
        .i_life_new (r_life_new),
        .i_live     (c_live[0]),
        .i_age      (c_age[0]),
        .i_life     (c_life[0]),
        .o_live     (h_live),
        .o_age      (h_age),
        .o_life     (h_life),
        .o_expired  (h_expired)
    );

    for (genvar k = 0; k < SLOTS; k++) begin : g_ring
        logic          nb_live;
        logic [TW-1:0] nb_age;
        logic [TW-1:0] nb_life;
        if (k == SLOTS - 1) begin : g_tail
            assign nb_live = h_live;
            assign nb_age  = h_age;
            assign nb_life = h_life;
        end else begin : g_mid
            assign nb_live = c_live[k+1];
            assign nb_age  = c_age[k+1];
            assign nb_life = c_life[k+1];
        end
        espar_cell #(.TW(TW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_live  (nb_live),
            .i_age   (nb_age),
            .i_life  (nb_life),
            .o_live  (c_live[k]),
            .o_age   (c_age[k]),
            .o_life  (c_life[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.func == FUNC_TICK) ? ST_TICK : ST_SCAN_MUL;
                end
            end
            ST_SCAN_MUL: n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: n_state = (r_idx == LAST_IDX) ? ST_WRITE : ST_SCAN_MUL;
            ST_WRITE:    if (r_idx == LAST_IDX) n_state = ST_OUT;
            ST_TICK:     if (r_idx == LAST_IDX) n_state = ST_OUT;
            ST_OUT:      if (out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_live_cnt  <= '0;
            r_exp_cnt   <= '0;
            r_rng       <= RNG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_exp_cnt <= '0;
            end
            if (shift) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (r_state == ST_SCAN_CMP && !c_live[0] && !r_found) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_TICK && h_expired) begin
                r_exp_cnt <= r_exp_cnt + 1'b1;
            end
            if (out_load) begin
                if (r_func == FUNC_TICK) begin
                    r_live_cnt <= r_live_cnt - r_exp_cnt;
                end else begin
                    r_live_cnt <= r_live_cnt + CW'(r_found);
                    r_rng      <= rng_next;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func      <= i_in.func;
            r_life_new  <= (req_t < MIN_EFF) ? MIN_EFF : req_t;
            r_dt        <= TW'(i_in.elapsed);
            r_best_idx  <= '0;
            r_best_age  <= c_age[0];
            r_best_life <= c_life[0];
        end
        if (r_state == ST_SCAN_MUL) begin
            r_prod_l <= (2*TW)'(c_age[0]) * (2*TW)'(r_best_life);
            r_prod_r <= (2*TW)'(r_best_age) * (2*TW)'(c_life[0]);
        end
        if (r_state == ST_SCAN_CMP) begin
            if (!c_live[0] && !r_found) begin
                r_free_idx <= r_idx;
            end
            if (r_prod_l > r_prod_r) begin
                r_best_idx  <= r_idx;
                r_best_age  <= c_age[0];
                r_best_life <= c_life[0];
            end
        end
        if (out_load) begin
            if (r_func == FUNC_TICK) begin
                r_out_idx  <= '0;
                r_out_repl <= 1'b0;
                r_out_seed <= '0;
                r_out_exp  <= CNT_W'(r_exp_cnt);
                r_out_live <= CNT_W'(r_live_cnt - r_exp_cnt);
            end else begin
                r_out_idx  <= IDX_W'(pick);
                r_out_repl <= !r_found;
                r_out_seed <= rng_next;
                r_out_exp  <= '0;
                r_out_live <= CNT_W'(r_live_cnt + CW'(r_found));
            end
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.slot_index    = r_out_idx;
    assign o_out.replaced_live = r_out_repl;
    assign o_out.seed_word     = r_out_seed;
    assign o_out.expired_count = r_out_exp;
    assign o_out.live_count    = r_out_live;

endmodule
`default_nettype wire

### sv/espar_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espar_cell
// One slot of the ring: live flag, age and lifetime, passed on when shifting.
// ----------------------------------------------------------------------------
module espar_cell import espar_pkg::*; #(
    parameter int TW = TIME_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire logic          i_live,
    input  wire logic [TW-1:0] i_age,
    input  wire logic [TW-1:0] i_life,
    output logic               o_live,
    output logic [TW-1:0]      o_age,
    output logic [TW-1:0]      o_life
);

    logic          r_live;
    logic [TW-1:0] r_age;
    logic [TW-1:0] r_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_shift) begin
            r_live <= i_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_age  <= i_age;
            r_life <= i_life;
        end
    end

    assign o_live = r_live;
    assign o_age  = r_age;
    assign o_life = r_life;

endmodule
`default_nettype wire

### sv/espar_head.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espar_head
// Update unit at the ring head: tick aging/retire, or spawn write.
// ----------------------------------------------------------------------------
module espar_head import espar_pkg::*; #(
    parameter int TW = TIME_BITS_DEF
) (
    input  wire t_head_cmd     i_cmd,
    input  wire logic [TW-1:0] i_dt,
    input  wire logic [TW-1:0] i_life_new,
    input  wire logic          i_live,
    input  wire logic [TW-1:0] i_age,
    input  wire logic [TW-1:0] i_life,
    output logic               o_live,
    output logic [TW-1:0]      o_age,
    output logic [TW-1:0]      o_life,
    output logic               o_expired
);

    logic [TW:0]   sum;
    logic [TW-1:0] age_sat;

    assign sum     = {1'b0, i_age} + {1'b0, i_dt};
    assign age_sat = sum[TW] ? '1 : sum[TW-1:0];

    always_comb begin
        o_live    = i_live;
        o_age     = i_age;
        o_life    = i_life;
        o_expired = 1'b0;
        if (i_cmd.write) begin
            o_live = 1'b1;
            o_age  = '0;
            o_life = i_life_new;
        end else if (i_cmd.tick && i_live) begin
            o_age = age_sat;
            if (age_sat >= i_life) begin
                o_live    = 1'b0;
                o_expired = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
